// ----- sv/sec_pkg.sv -----
// Shared types, constants and character helpers for the s-expression
// command splitter. No dependencies; imported by every module of the block.
package sec_pkg;

  // Bracket depth width and its saturation limits
  localparam int unsigned DEPTH_BITS = 8;
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_ZERO = '0;
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  // Keyword matcher positions
  localparam logic [3:0] KEY_LEN  = 4'd9;
  localparam logic [3:0] NO_MATCH = 4'd15;

  // Characters with a meaning to the scanner
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_OPEN      = 8'h28;
  localparam logic [7:0] CH_CLOSE     = 8'h29;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Command kind codes carried on the last beat
  localparam logic [1:0] KIND_ORDINARY  = 2'd0;
  localparam logic [1:0] KIND_CHECK_SAT = 2'd1;
  localparam logic [1:0] KIND_ENDED     = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } sec_result_t;

  typedef struct packed {
    logic                         skip_newlines;
    logic                         seen_open;
    logic                         in_comment;
    logic                         escape_pending;
    logic                         in_quote;
    logic signed [DEPTH_BITS-1:0] depth;
    logic [3:0]                   match_pos;
    logic                         check_found;
  } sec_state_t;

  localparam sec_state_t STATE_RESET = '{
    skip_newlines:  1'b1,
    seen_open:      1'b0,
    in_comment:     1'b0,
    escape_pending: 1'b0,
    in_quote:       1'b0,
    depth:          DEPTH_ZERO,
    match_pos:      NO_MATCH,
    check_found:    1'b0
  };

  // Letter of "check-sat" at a given match position
  function automatic logic [7:0] keyword_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h68; // h
      4'd2:    ch = 8'h65; // e
      4'd3:    ch = 8'h63; // c
      4'd4:    ch = 8'h6B; // k
      4'd5:    ch = 8'h2D; // -
      4'd6:    ch = 8'h73; // s
      4'd7:    ch = 8'h61; // a
      4'd8:    ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ----- sv/sec_in_if.sv -----
// Input channel of the command splitter: one text byte or end marker per beat.
// Depends on nothing.
interface sec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_input;

  modport source (output valid, output byte_value, output end_of_input, input ready);
  modport sink (input valid, input byte_value, input end_of_input, output ready);
endinterface

// ----- sv/sec_out_if.sv -----
// Result channel of the command splitter: one echoed byte or end marker per beat.
// Depends on nothing.
interface sec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ----- sv/sexpr_command_splitter_core.sv -----
// S-expression command splitter: cuts a byte stream into bracketed commands.
// Depends on sec_pkg, sec_in_if, sec_out_if, sec_scanner, sec_out_stage,
// sec_port_check.
//
// Usage:
//   in_ch  carries one text byte per beat, or an end-of-input marker.
//   out_ch carries one echoed byte per kept input byte; the byte that closes
//          a command has last set and kind 0 (ordinary) or 1 (check-sat).
//          An end-of-input beat gives out_byte 0, kind 2, last 1.
//   Newlines before a command yield no result beat.
//   A result is offered the cycle after its byte is accepted.
//   Throughput: one byte per cycle while the receiver keeps up; the scanner
//   next state is combinational and feeds straight back for the next byte.
//   in_ch.ready is high while the result register is empty or is being
//   emptied in the same cycle, so a stalled receiver holds one result and
//   blocks further input until it takes it; nothing is lost.
//   Reset (rst_n low, synchronous) empties the result register and puts the
//   scanner in its start state, skipping leading newlines.
module sexpr_command_splitter_core
  import sec_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  sec_in_if.sink    in_ch,
  sec_out_if.source out_ch
);

  logic        in_fire;
  logic        free;
  logic        res_valid;
  sec_result_t res;
  sec_result_t out_res;

  assign in_ch.ready = free;
  assign in_fire     = in_ch.valid && free;

  sec_scanner u_scanner (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .byte_value   (in_ch.byte_value),
    .end_of_input (in_ch.end_of_input),
    .res_valid    (res_valid),
    .res          (res)
  );

  sec_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .free      (free)
  );

  // Drive the result channel payload
  assign out_ch.out_byte = out_res.out_byte;
  assign out_ch.kind     = out_res.kind;
  assign out_ch.last     = out_res.last;

  sec_port_check u_port_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.kind),
    .last      (out_ch.last)
  );

endmodule

// ----- sv/sec_scanner.sv -----
// Per-byte scanner: comment, quote, escape, depth and keyword tracking.
// Holds the splitter state; depends on sec_pkg.
module sec_scanner
  import sec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [7:0]  byte_value,
  input  logic        end_of_input,
  output logic        res_valid,
  output sec_result_t res
);

  sec_state_t state_r;
  sec_state_t state_nxt;

  // Work out the next state and the result for the byte on offer
  always_comb begin
    sec_state_t s;
    logic       was_escaped;
    s           = state_r;
    was_escaped = 1'b0;
    res_valid   = 1'b1;
    res         = '{out_byte: byte_value, kind: KIND_ORDINARY, last: 1'b0};

    if (end_of_input) begin
      res = '{out_byte: 8'h00, kind: KIND_ENDED, last: 1'b1};
      s   = STATE_RESET;
    end else if (state_r.skip_newlines && byte_value == CH_LF) begin
      res_valid = 1'b0;
    end else begin
      s.skip_newlines = 1'b0;
      if (state_r.in_comment) begin
        s.match_pos = NO_MATCH;
        if (byte_value == CH_LF) begin
          s.in_comment = 1'b0;
        end
      end else if (byte_value == CH_BACKSLASH) begin
        s.escape_pending = !state_r.escape_pending;
      end else begin
        was_escaped      = state_r.escape_pending;
        s.escape_pending = 1'b0;
        if (!was_escaped || state_r.in_quote) begin
          if (byte_value == CH_BAR) begin
            s.match_pos = NO_MATCH;
            s.in_quote  = !state_r.in_quote;
          end else if (!state_r.in_quote) begin
            // Plain text outside quotes
            if (byte_value == CH_SEMI) begin
              s.in_comment = 1'b1;
              s.match_pos  = NO_MATCH;
            end else if (byte_value == CH_OPEN) begin
              if (state_r.depth < DEPTH_MAX) begin
                s.depth = state_r.depth + DEPTH_ONE;
              end
              s.seen_open = 1'b1;
              s.match_pos = (s.depth == DEPTH_ONE) ? 4'd0 : NO_MATCH;
            end else if (byte_value == CH_CLOSE) begin
              if (state_r.depth > DEPTH_MIN) begin
                s.depth = state_r.depth - DEPTH_ONE;
              end
              if (s.depth == DEPTH_ZERO && state_r.match_pos == KEY_LEN) begin
                s.check_found = 1'b1;
              end
              s.match_pos = NO_MATCH;
            end else if (state_r.match_pos < KEY_LEN) begin
              if (!is_space(byte_value)) begin
                s.match_pos = (byte_value == keyword_char(state_r.match_pos)) ?
                              state_r.match_pos + 4'd1 : NO_MATCH;
              end
            end else if (state_r.match_pos == KEY_LEN) begin
              if (!is_space(byte_value)) begin
                s.match_pos = NO_MATCH;
              end
            end else begin
              s.match_pos = NO_MATCH;
            end
          end
        end else begin
          s.match_pos = NO_MATCH;
        end
      end

      // Close the command when the depth comes back to zero
      if (s.depth == DEPTH_ZERO && s.seen_open) begin
        res.kind = s.check_found ? KIND_CHECK_SAT : KIND_ORDINARY;
        res.last = 1'b1;
        s        = STATE_RESET;
      end
    end
    state_nxt = s;
  end

  // Advance the state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // An open bracket at depth zero would already have closed the command
  a_open_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.seen_open |-> state_r.depth != DEPTH_ZERO)
    else $error("seen_open held with zero depth");

  // The keyword flag is consumed by the same beat that sets it
  a_found_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.check_found)
    else $error("check_found left set after a beat");

  // Matcher position is a letter count or the no-match code
  a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.match_pos <= KEY_LEN || state_r.match_pos == NO_MATCH)
    else $error("match_pos out of range");

  // End of input returns the scanner to its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && end_of_input |=> state_r == STATE_RESET)
    else $error("state not cleared after end of input");

endmodule

// ----- sv/sec_out_stage.sv -----
// Result register between the scanner and the result channel.
// Depends on sec_pkg.
module sec_out_stage
  import sec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  sec_result_t res,
  input  logic        out_ready,
  output logic        out_valid,
  output sec_result_t out_res,
  output logic        free
);

  logic        valid_r;
  logic        valid_nxt;
  sec_result_t res_r;

  // Space for a new beat when empty or when the held one leaves now
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Never load over a beat that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result register overwritten while stalled");

  // A load always shows a beat on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded beat not presented");

  // End results carry a zero byte and the last flag
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.kind == KIND_ENDED |-> res_r.last && res_r.out_byte == 8'h00)
    else $error("malformed end result");

endmodule

// ----- sv/sec_top_dummy_never.sv -----
// Result channel checker for the command splitter: watches the handshake and
// the kind and last fields at the top-level ports only. Depends on sec_pkg.
module sec_port_check
  import sec_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic       last
);

  // A stalled beat stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Kind is only non-zero on the last beat of a command
  a_kind_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> kind == KIND_ORDINARY)
    else $error("kind set on a middle beat");

  // Kind code stays in range
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> kind == KIND_ORDINARY || kind == KIND_CHECK_SAT || kind == KIND_ENDED)
    else $error("unknown kind code");

endmodule

// ----- verif/sexpr_command_splitter_core_tb.sv -----
// Self-checking testbench for sexpr_command_splitter_core: drives text beats,
// mirrors the splitter's scanner state and checks every echoed beat in order.
// Depends on sec_pkg, sec_in_if, sec_out_if and the block itself.
module sexpr_command_splitter_core_tb;
  import sec_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1550;
  localparam int unsigned CALM_TAIL    = 200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 200000;

  // Mirror of the splitter scanner plus the queue of echoes still owed
  class splitter_scoreboard;
    sec_state_t  scan;
    sec_result_t pending_echoes[$];
    int unsigned errors;
    string       word;

    function new();
      scan = STATE_RESET;
      errors = 0;
      word = "check-sat";
    endfunction

    function logic blank_char(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Advance the bracket/keyword tracker for a byte outside comment and quote
    function void scan_plain(input logic [7:0] c);
      if (c == CH_SEMI) begin
        scan.in_comment = 1'b1;
        scan.match_pos = NO_MATCH;
      end else if (c == CH_OPEN) begin
        if (scan.depth < DEPTH_MAX) scan.depth = scan.depth + DEPTH_ONE;
        scan.seen_open = 1'b1;
        scan.match_pos = (scan.depth == DEPTH_ONE) ? 4'd0 : NO_MATCH;
      end else if (c == CH_CLOSE) begin
        if (scan.depth > DEPTH_MIN) scan.depth = scan.depth - DEPTH_ONE;
        if (scan.depth == DEPTH_ZERO && scan.match_pos == KEY_LEN) scan.check_found = 1'b1;
        scan.match_pos = NO_MATCH;
      end else if (scan.match_pos < KEY_LEN) begin
        if (!blank_char(c))
          scan.match_pos = (c == word[scan.match_pos]) ? scan.match_pos + 4'd1 : NO_MATCH;
      end else if (scan.match_pos == KEY_LEN) begin
        if (!blank_char(c)) scan.match_pos = NO_MATCH;
      end else begin
        scan.match_pos = NO_MATCH;
      end
    endfunction

    // Work out the echo owed for one accepted input beat
    function void note_input_beat(input logic [7:0] c, input logic eoi);
      sec_result_t echo;
      logic        was_escaped;
      if (eoi) begin
        echo.out_byte = 8'h00;
        echo.kind = KIND_ENDED;
        echo.last = 1'b1;
        pending_echoes.push_back(echo);
        scan = STATE_RESET;
        return;
      end
      // Drop newlines ahead of a command
      if (scan.skip_newlines && c == CH_LF) return;
      scan.skip_newlines = 1'b0;
      if (scan.in_comment) begin
        scan.match_pos = NO_MATCH;
        if (c == CH_LF) scan.in_comment = 1'b0;
      end else if (c == CH_BACKSLASH) begin
        scan.escape_pending = !scan.escape_pending;
      end else begin
        was_escaped = scan.escape_pending;
        scan.escape_pending = 1'b0;
        if (!was_escaped || scan.in_quote) begin
          if (c == CH_BAR) begin
            scan.match_pos = NO_MATCH;
            scan.in_quote = !scan.in_quote;
          end else if (!scan.in_quote) begin
            scan_plain(c);
          end
        end else begin
          scan.match_pos = NO_MATCH;
        end
      end
      echo.out_byte = c;
      if (scan.depth == DEPTH_ZERO && scan.seen_open) begin
        echo.kind = scan.check_found ? KIND_CHECK_SAT : KIND_ORDINARY;
        echo.last = 1'b1;
        scan = STATE_RESET;
      end else begin
        echo.kind = KIND_ORDINARY;
        echo.last = 1'b0;
      end
      pending_echoes.push_back(echo);
    endfunction

    // Compare a result beat with the oldest echo owed
    function void check_result(input sec_result_t got);
      sec_result_t want;
      if (pending_echoes.size() == 0) begin
        $error("unexpected result beat: out_byte %0h kind %0d last %0b",
               got.out_byte, got.kind, got.last);
        errors++;
        return;
      end
      want = pending_echoes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  sec_in_if  in_ch();
  sec_out_if out_ch();

  splitter_scoreboard sb = new();
  int unsigned sent_beats = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  sexpr_command_splitter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check every result beat taken
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_byte: out_ch.out_byte, kind: out_ch.kind, last: out_ch.last});
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        out_ch.ready <= 1'b1;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one beat, with an optional idle burst first, and wait for acceptance
  task automatic send_item(input logic [7:0] b, input logic eoi);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input_beat(b, eoi);
    sent_beats++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  task automatic send_blanks(input int unsigned most);
    repeat ($urandom_range(0, most)) send_item(pick_blank(), 1'b0);
  endtask

  // Top-level check-sat with blanks between letters; some are spoilt
  task automatic send_check_sat();
    int unsigned spoil;
    int unsigned bad_pos;
    string       word;
    logic [7:0]  ch;
    word = "check-sat";
    spoil = $urandom_range(0, 5);
    bad_pos = $urandom_range(0, 8);
    send_blanks(2);
    send_item(CH_OPEN, 1'b0);
    if (spoil == 2) send_item(CH_OPEN, 1'b0);
    for (int i = 0; i < 9; i++) begin
      send_blanks(1);
      ch = word[i];
      if (spoil == 0 && i == bad_pos) ch = 8'h78;
      send_item(ch, 1'b0);
    end
    send_blanks(2);
    if (spoil == 1) send_text(" x");
    send_item(CH_CLOSE, 1'b0);
    if (spoil == 2) send_item(CH_CLOSE, 1'b0);
  endtask

  function automatic logic [7:0] pick_tricky();
    case ($urandom_range(0, 6))
      0:       return CH_OPEN;
      1:       return CH_CLOSE;
      2:       return CH_SEMI;
      3:       return CH_BACKSLASH;
      4:       return CH_SPACE;
      5:       return CH_BAR;
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // Well-formed command with random nesting, atoms, quotes, comments, escapes
  task automatic send_command();
    int unsigned level;
    logic [7:0]  ch;
    level = 1;
    send_blanks(3);
    send_item(CH_OPEN, 1'b0);
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 7))
        0: if (level < 5) begin
          send_item(CH_OPEN, 1'b0);
          level++;
        end
        1: if (level > 1) begin
          send_item(CH_CLOSE, 1'b0);
          level--;
        end
        2: begin
          repeat ($urandom_range(1, 5)) send_item(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
          send_item(CH_SPACE, 1'b0);
        end
        3: begin
          send_item(CH_BAR, 1'b0);
          repeat ($urandom_range(0, 4)) begin
            ch = pick_tricky();
            if (ch == CH_BAR) ch = CH_OPEN;
            send_item(ch, 1'b0);
          end
          send_item(CH_BAR, 1'b0);
        end
        4: begin
          send_item(CH_SEMI, 1'b0);
          repeat ($urandom_range(0, 5)) begin
            ch = pick_tricky();
            if (ch == CH_LF) ch = CH_SPACE;
            send_item(ch, 1'b0);
          end
          send_item(CH_LF, 1'b0);
        end
        5: begin
          send_item(CH_BACKSLASH, 1'b0);
          ch = pick_tricky();
          if (ch == CH_SEMI) ch = CH_BACKSLASH;
          send_item(ch, 1'b0);
        end
        6: send_item(pick_blank(), 1'b0);
        default: send_text("check-sat ");
      endcase
    end
    while (level > 0) begin
      send_item(CH_CLOSE, 1'b0);
      level--;
    end
  endtask

  // Run the depth into saturation, positive or negative, and back to zero
  task automatic send_deep(input bit negative);
    if (negative) begin
      repeat (130) send_item(CH_CLOSE, 1'b0);
      repeat (128) send_item(CH_OPEN, 1'b0);
    end else begin
      repeat (130) send_item(CH_OPEN, 1'b0);
      repeat (130) send_item(CH_CLOSE, 1'b0);
      repeat (3) send_item(CH_OPEN, 1'b0);
    end
  endtask

  initial begin
    bit hold_done;
    int unsigned next_mood;
    int unsigned pick;
    hold_done = 1'b0;
    next_mood = 150;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.byte_value <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: leading newline, check-sat, stray close, end marker,
    // comment, escaped bar outside and inside a quote, top bit set
    send_text("\n(check-sat)");
    send_text(")(");
    send_item(8'hFF, 1'b1);
    send_text("(;)\n)");
    send_text("(\\|)");
    send_text("(|\\|)");
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b1);

    send_deep(1'b0);
    send_deep(1'b1);

    // Random: mostly well-formed commands, some noise and broken streams
    while (sent_beats < ITEM_TARGET) begin
      if (!hold_done && sent_beats >= 700) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (sent_beats >= next_mood) begin
        idle_on = ($urandom_range(0, 2) != 0);
        next_mood += 150;
      end
      if (sent_beats >= ITEM_TARGET - CALM_TAIL) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 45) send_command();
      else if (pick < 70) send_check_sat();
      else if (pick < 80) begin
        repeat ($urandom_range(1, 8)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 86) send_item(8'($urandom_range(0, 255)), 1'b1);
      else if (pick < 92) begin
        repeat ($urandom_range(1, 3)) send_item(CH_CLOSE, 1'b0);
        repeat ($urandom_range(1, 3)) send_item(CH_OPEN, 1'b0);
      end else begin
        send_text("\n\n");
        send_command();
      end
    end
    send_item(8'h00, 1'b1);

    // Drain and let the result stage settle
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_echoes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sec_pkg.sv
sv/sec_in_if.sv
sv/sec_out_if.sv
sv/sec_scanner.sv
sv/sec_out_stage.sv
sv/sec_top_dummy_never.sv
sv/sexpr_command_splitter_core.sv
verif/sexpr_command_splitter_core_tb.sv
